// ===== src/nlt_pkg.sv =====
// ----------------------------------------------------------------------------
// nlt_pkg
// Shared constants, codes and types of the neighbor liveness table.
// ----------------------------------------------------------------------------
package nlt_pkg;

	// table geometry
	localparam int MAX_NEIGHBORS = 16;
	localparam int ADDR_BITS     = 8;
	localparam int IDX_W         = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
	localparam int CNT_W         = $clog2(MAX_NEIGHBORS + 1);
	localparam int AGE_W         = 8;

	// field widths
	localparam int FUNC_W    = 2;
	localparam int PEER_W    = 8;
	localparam int KIND_W    = 2;
	localparam int TGT_W     = 8;
	localparam int CFG_W     = 8;
	localparam int CFG_IDX_W = 2;

	// event kinds
	localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_RECV = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_FAIL = 2'd2;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_HELLO = 2'd0;
	localparam logic [KIND_W-1:0] KIND_PING  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_FOUND = 2'd2;
	localparam logic [KIND_W-1:0] KIND_LOST  = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_HELLO_PERIOD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BCAST_ADDR   = 2'd2;

	// configuration reset values
	localparam logic [CFG_W-1:0] HELLO_PERIOD_RST = 8'd10;
	localparam logic [CFG_W-1:0] TIMEOUT_RST      = 8'd20;
	localparam logic [CFG_W-1:0] BCAST_ADDR_RST   = 8'd255;

	// one table entry
	typedef struct packed {
		logic [ADDR_BITS-1:0] addr;
		logic [AGE_W-1:0]     age;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// shared entry unit outputs
	typedef struct packed {
		logic             addr_hit;
		logic             age_hit;
		logic [AGE_W-1:0] age_inc;
	} unit_res_t;

	// one result item
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [TGT_W-1:0]  target_addr;
		logic              stored;
		logic              last;
	} result_t;

endpackage

// ===== src/nlt_if.sv =====
// ----------------------------------------------------------------------------
// nlt_req_if / nlt_rsp_if
// Valid/ready channels for event requests and result items.
// ----------------------------------------------------------------------------
interface nlt_req_if;
	import nlt_pkg::*;

	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	logic [PEER_W-1:0] peer_addr;

	modport source (output valid, func, peer_addr, input ready);
	modport sink   (input valid, func, peer_addr, output ready);
endinterface

interface nlt_rsp_if;
	import nlt_pkg::*;

	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [TGT_W-1:0]  target_addr;
	logic              stored;
	logic              last;

	modport source (output valid, kind, target_addr, stored, last, input ready);
	modport sink   (input valid, kind, target_addr, stored, last, output ready);
endinterface

// ===== src/nlt_ram.sv =====
// ----------------------------------------------------------------------------
// nlt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nlt_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== src/nlt_entry_unit.sv =====
// ----------------------------------------------------------------------------
// nlt_entry_unit
// Shared per-entry unit: address match, timeout match and age increment.
// ----------------------------------------------------------------------------
module nlt_entry_unit (
	input  nlt_pkg::entry_t                  entry,
	input  logic [nlt_pkg::ADDR_BITS-1:0]    peer,
	input  logic [nlt_pkg::AGE_W-1:0]        timeout,
	output nlt_pkg::unit_res_t               res
);
	import nlt_pkg::*;

	// compares and the wrapping age step
	assign res.addr_hit = (entry.addr == peer);
	assign res.age_hit  = (entry.age == timeout);
	assign res.age_inc  = AGE_W'(entry.age + 1'b1);
endmodule

// ===== src/neighbor_liveness_table.sv =====
// ----------------------------------------------------------------------------
// neighbor_liveness_table
// Mesh neighbor table with hello timing, keepalive pings and add/remove.
// ----------------------------------------------------------------------------
// Usage
//   req carries one event (tick, frame received, send failure); rsp returns
//   the result items it causes, the final one flagged by last. Registers
//   (hello period, neighbor timeout, broadcast address) are written through
//   cfg_we/cfg_index/cfg_data; the user must do so only while the block is
//   idle, the block itself does not enforce it.
//   Events are processed one at a time; req.ready is high only between them.
//   The table sits in a single-port-read RAM of at most 16 neighbors, and
//   one entry unit examines one entry per cycle unless rsp stalls the scan;
//   a receive or a send failure stops its search at the first matching entry.
//   An unused event kind returns nothing.
//   Results are held in an output register plus one pending slot, so the
//   last flag can be set once the scan is over; when rsp stalls, the scan
//   waits at the entry that wants to emit and resumes without loss.
//   Reset clears the hello counter, the neighbor count and the registers
//   to their defaults; table contents are not cleared, no clearing pass is
//   needed.
// ----------------------------------------------------------------------------
module neighbor_liveness_table (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [nlt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [nlt_pkg::CFG_W-1:0]      cfg_data,
	nlt_req_if.sink                        req,
	nlt_rsp_if.source                      rsp
);
	import nlt_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SCAN   = 5'b00010,
		ST_SEARCH = 5'b00100,
		ST_MOVE   = 5'b01000,
		ST_FLUSH  = 5'b10000
	} state_t;

	state_t               state_q, state_d;
	logic [CFG_W-1:0]     hello_period_q, timeout_q, bcast_addr_q;
	logic [AGE_W-1:0]     hello_count_q, hello_count_d;
	logic [CNT_W-1:0]     count_q, count_d;
	logic [CNT_W-1:0]     idx_q, idx_d, idx_inc, count_m1;
	logic [FUNC_W-1:0]    func_q, func_d;
	logic [ADDR_BITS-1:0] peer_q, peer_d;
	logic [IDX_W-1:0]     match_q, match_d;
	logic                 pend_valid_q, pend_valid_d;
	result_t              pend_q, pend_d;
	logic                 out_valid_q;
	result_t              out_q, out_d;
	logic                 out_load, out_free;

	logic                 ram_we;
	logic [IDX_W-1:0]     ram_waddr, ram_raddr;
	entry_t               ram_wdata, ram_rdata;
	unit_res_t            unit;

	// neighbor table storage
	nlt_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_NEIGHBORS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// shared compare/increment unit on the entry just read
	nlt_entry_unit u_unit (
		.entry   (ram_rdata),
		.peer    (peer_q),
		.timeout (timeout_q),
		.res     (unit)
	);

	assign idx_inc  = CNT_W'(idx_q + 1'b1);
	assign count_m1 = CNT_W'(count_q - 1'b1);
	assign out_free = !out_valid_q || rsp.ready;
	assign req.ready = (state_q == ST_IDLE);

	// sequencer
	always_comb begin
		state_d       = state_q;
		hello_count_d = hello_count_q;
		count_d       = count_q;
		idx_d         = idx_q;
		func_d        = func_q;
		peer_d        = peer_q;
		match_d       = match_q;
		pend_valid_d  = pend_valid_q;
		pend_d        = pend_q;
		out_load      = 1'b0;
		out_d         = pend_q;
		out_d.last    = 1'b0;
		ram_we        = 1'b0;
		ram_waddr     = idx_q[IDX_W-1:0];
		ram_wdata     = ram_rdata;
		ram_raddr     = '0;

		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					func_d = req.func;
					peer_d = req.peer_addr[ADDR_BITS-1:0];
					idx_d  = '0;
					case (req.func)
						FUNC_TICK: begin
							if (hello_count_q == hello_period_q) begin
								pend_valid_d       = 1'b1;
								pend_d.kind        = KIND_HELLO;
								pend_d.target_addr = bcast_addr_q;
								pend_d.stored      = 1'b0;
								pend_d.last        = 1'b0;
								hello_count_d      = '0;
							end else begin
								hello_count_d = AGE_W'(hello_count_q + 1'b1);
							end
							state_d = ST_SCAN;
						end
						FUNC_RECV, FUNC_FAIL: begin
							state_d = ST_SEARCH;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end

			// tick: ping entries at timeout, age every entry
			ST_SCAN: begin
				ram_raddr = idx_q[IDX_W-1:0];
				if (idx_q == count_q) begin
					state_d = ST_FLUSH;
				end else if (!(unit.age_hit && pend_valid_q && !out_free)) begin
					ram_we        = 1'b1;
					ram_wdata.age = unit.age_inc;
					idx_d         = idx_inc;
					ram_raddr     = idx_inc[IDX_W-1:0];
					if (unit.age_hit) begin
						if (pend_valid_q) begin
							out_load = 1'b1;
						end
						pend_valid_d       = 1'b1;
						pend_d.kind        = KIND_PING;
						pend_d.target_addr = TGT_W'(ram_rdata.addr);
						pend_d.stored      = 1'b0;
						pend_d.last        = 1'b0;
					end
				end
			end

			// receive / failure: find the first matching entry
			ST_SEARCH: begin
				ram_raddr = idx_inc[IDX_W-1:0];
				if (idx_q == count_q) begin
					pend_valid_d       = 1'b1;
					pend_d.target_addr = TGT_W'(peer_q);
					pend_d.stored      = 1'b0;
					pend_d.last        = 1'b0;
					if (func_q == FUNC_RECV) begin
						pend_d.kind = KIND_FOUND;
						if (count_q < CNT_W'(MAX_NEIGHBORS)) begin
							ram_we         = 1'b1;
							ram_waddr      = count_q[IDX_W-1:0];
							ram_wdata.addr = peer_q;
							ram_wdata.age  = '0;
							count_d        = CNT_W'(count_q + 1'b1);
							pend_d.stored  = 1'b1;
						end
					end else begin
						pend_d.kind = KIND_LOST;
					end
					state_d = ST_FLUSH;
				end else if (unit.addr_hit) begin
					if (func_q == FUNC_RECV) begin
						ram_we        = 1'b1;
						ram_wdata.age = '0;
						state_d       = ST_IDLE;
					end else begin
						match_d   = idx_q[IDX_W-1:0];
						ram_raddr = count_m1[IDX_W-1:0];
						state_d   = ST_MOVE;
					end
				end else begin
					idx_d = idx_inc;
				end
			end

			// failure: move the last entry into the freed slot
			ST_MOVE: begin
				ram_we             = 1'b1;
				ram_waddr          = match_q;
				ram_wdata          = ram_rdata;
				count_d            = count_m1;
				pend_valid_d       = 1'b1;
				pend_d.kind        = KIND_LOST;
				pend_d.target_addr = TGT_W'(peer_q);
				pend_d.stored      = 1'b0;
				pend_d.last        = 1'b0;
				state_d            = ST_FLUSH;
			end

			// hand over the final result, if any, with last set
			ST_FLUSH: begin
				if (!pend_valid_q) begin
					state_d = ST_IDLE;
				end else if (out_free) begin
					out_load     = 1'b1;
					out_d.last   = 1'b1;
					pend_valid_d = 1'b0;
					state_d      = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			hello_count_q <= '0;
			count_q       <= '0;
			pend_valid_q  <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q       <= state_d;
			hello_count_q <= hello_count_d;
			count_q       <= count_d;
			pend_valid_q  <= pend_valid_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hello_period_q <= HELLO_PERIOD_RST;
			timeout_q      <= TIMEOUT_RST;
			bcast_addr_q   <= BCAST_ADDR_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_HELLO_PERIOD: hello_period_q <= cfg_data;
				CFG_TIMEOUT:      timeout_q      <= cfg_data;
				CFG_BCAST_ADDR:   bcast_addr_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		idx_q   <= idx_d;
		func_q  <= func_d;
		peer_q  <= peer_d;
		match_q <= match_d;
		pend_q  <= pend_d;
		if (out_load) begin
			out_q <= out_d;
		end
	end

	// result channel
	assign rsp.valid       = out_valid_q;
	assign rsp.kind        = out_q.kind;
	assign rsp.target_addr = out_q.target_addr;
	assign rsp.stored      = out_q.stored;
	assign rsp.last        = out_q.last;

	// the pending slot is always drained before a new request is taken
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !pend_valid_q)
		else $error("pending result left over in idle");

	// neighbor count stays within the table
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_NEIGHBORS))
		else $error("neighbor count beyond table depth");

	// neither the tick scan nor the search walks past the stored entries
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN || state_q == ST_SEARCH) |-> idx_q <= count_q)
		else $error("scan index past neighbor count");

	// a result is never loaded over one that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> out_free)
		else $error("result register overwritten");

	// a removal shrinks the table by exactly one
	a_move_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MOVE) |=> count_q == CNT_W'($past(count_q) - 1'b1))
		else $error("removal did not shrink the table");
endmodule

// ===== test/neighbor_table_checker.sv =====
// ----------------------------------------------------------------------------
// neighbor_table_checker
// Watches the register port and both channels of the neighbor liveness table,
// keeps its own copy of the table, counters and registers, works out the
// results of every accepted request and compares them in order with the
// results the block hands out.
// ----------------------------------------------------------------------------
module neighbor_table_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [nlt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [nlt_pkg::CFG_W-1:0]     cfg_data,
	nlt_req_if                            req,
	nlt_rsp_if                            rsp,
	output int                            fail_count,
	output int                            pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import nlt_pkg::*;

	localparam int REPORT_MAX = 10;

	// register copies
	logic [CFG_W-1:0] period_r;
	logic [CFG_W-1:0] timeout_r;
	logic [CFG_W-1:0] bcast_r;

	// table copy
	logic [AGE_W-1:0]     hello_ticks;
	int                   tbl_count;
	logic [ADDR_BITS-1:0] tbl_addr [MAX_NEIGHBORS];
	logic [AGE_W-1:0]     tbl_age  [MAX_NEIGHBORS];

	// results still owed by the block, oldest first
	result_t owed_results [$];
	int      errors;

	assign fail_count = errors;

	function automatic result_t make_result(logic [KIND_W-1:0] k, logic [TGT_W-1:0] t,
			logic s);
		result_t r;
		r.kind        = k;
		r.target_addr = t;
		r.stored      = s;
		r.last        = 1'b0;
		return r;
	endfunction

	// first table slot holding an address, or -1
	function automatic int find_entry(logic [ADDR_BITS-1:0] a);
		int i;
		for (i = 0; i < tbl_count; i++)
			if (tbl_addr[i] == a)
				return i;
		return -1;
	endfunction

	// apply one event to the table copy and queue the results it causes
	task automatic run_table_event(input logic [FUNC_W-1:0] f, input logic [PEER_W-1:0] peer);
		logic [ADDR_BITS-1:0] a;
		result_t              r;
		int                   n0;
		int                   hit;
		int                   i;
		a  = peer[ADDR_BITS-1:0];
		n0 = owed_results.size();
		case (f)
			FUNC_TICK: begin
				if (hello_ticks == period_r) begin
					owed_results.push_back(make_result(KIND_HELLO, bcast_r, 1'b0));
					hello_ticks = '0;
				end else begin
					hello_ticks = hello_ticks + 1'b1;
				end
				// ping every neighbor at the timeout, then age them all
				for (i = 0; i < tbl_count; i++) begin
					if (tbl_age[i] == timeout_r)
						owed_results.push_back(make_result(KIND_PING, tbl_addr[i], 1'b0));
					tbl_age[i] = tbl_age[i] + 1'b1;
				end
			end
			FUNC_RECV: begin
				hit = find_entry(a);
				if (hit >= 0) begin
					tbl_age[hit] = '0;
				end else if (tbl_count < MAX_NEIGHBORS) begin
					tbl_addr[tbl_count] = a;
					tbl_age[tbl_count]  = '0;
					tbl_count++;
					owed_results.push_back(make_result(KIND_FOUND, a, 1'b1));
				end else begin
					owed_results.push_back(make_result(KIND_FOUND, a, 1'b0));
				end
			end
			FUNC_FAIL: begin
				// last entry moves into the freed slot
				hit = find_entry(a);
				if (hit >= 0) begin
					tbl_count--;
					tbl_addr[hit] = tbl_addr[tbl_count];
					tbl_age[hit]  = tbl_age[tbl_count];
				end
				owed_results.push_back(make_result(KIND_LOST, a, 1'b0));
			end
			default: ;
		endcase
		// flag the final result of this event
		if (owed_results.size() > n0) begin
			r = owed_results[owed_results.size() - 1];
			r.last = 1'b1;
			owed_results[owed_results.size() - 1] = r;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			period_r    = HELLO_PERIOD_RST;
			timeout_r   = TIMEOUT_RST;
			bcast_r     = BCAST_ADDR_RST;
			hello_ticks = '0;
			tbl_count   = 0;
			errors      = 0;
			owed_results.delete();
			pending <= 0;
		end else begin
			// register writes
			if (cfg_we) begin
				case (cfg_index)
					CFG_HELLO_PERIOD: period_r  = cfg_data;
					CFG_TIMEOUT:      timeout_r = cfg_data;
					CFG_BCAST_ADDR:   bcast_r   = cfg_data;
					default: ;
				endcase
			end
			// compare a delivered result with the oldest one owed
			if (rsp.valid && rsp.ready) begin
				if (owed_results.size() == 0) begin
					errors++;
					if (errors <= REPORT_MAX)
						$display("[%0t] unexpected result: kind=%0d target=%02h stored=%0b last=%0b",
							$realtime, rsp.kind, rsp.target_addr, rsp.stored, rsp.last);
				end else begin
					want = owed_results.pop_front();
					if (rsp.kind !== want.kind || rsp.target_addr !== want.target_addr ||
							rsp.stored !== want.stored || rsp.last !== want.last) begin
						errors++;
						if (errors <= REPORT_MAX)
							$display({"[%0t] result mismatch: expected kind=%0d target=%02h ",
								"stored=%0b last=%0b, got kind=%0d target=%02h stored=%0b last=%0b"},
								$realtime, want.kind, want.target_addr, want.stored, want.last,
								rsp.kind, rsp.target_addr, rsp.stored, rsp.last);
					end
				end
			end
			// new request
			if (req.valid && req.ready)
				run_table_event(req.func, req.peer_addr);
			pending <= owed_results.size();
		end
	end

endmodule

// ===== test/neighbor_liveness_table_tb.sv =====
// ----------------------------------------------------------------------------
// neighbor_liveness_table_tb
// Drives ticks, received frames and send failures into the neighbor table in
// random bursts under several register settings, stalls the result channel
// on a changing pattern and lets the checker judge every result.
// ----------------------------------------------------------------------------
module neighbor_liveness_table_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import nlt_pkg::*;

	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
	localparam int POOL_SIZE   = 20;
	localparam int IDLE_TAIL   = 40;
	localparam int STALL_LIMIT = 2000;
	localparam int PHASE_ITEMS = 25;
	localparam int TICK_RUN    = 40;

	typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_BEAT} rx_mode_e;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]   cfg_data;
	int                 fail_count;
	int                 pending;
	int                 burst_left;
	logic [PEER_W-1:0]  peer_pool [POOL_SIZE];

	nlt_req_if req ();
	nlt_rsp_if rsp ();

	neighbor_liveness_table dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req),
		.rsp       (rsp)
	);

	neighbor_table_checker table_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.req        (req),
		.rsp        (rsp),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// result channel stalls, on a pattern picked at random for each random span
	initial begin
		rx_mode_e mode;
		int       span;
		rsp.ready <= 1'b0;
		mode = RX_OPEN;
		span = 0;
		forever begin
			@(posedge clk);
			if (span == 0) begin
				mode = rx_mode_e'($urandom_range(0, 3));
				span = $urandom_range(20, 80);
			end
			span--;
			case (mode)
				RX_OPEN:   rsp.ready <= 1'b1;
				RX_COIN:   rsp.ready <= ($urandom_range(0, 1) == 1);
				RX_SPARSE: rsp.ready <= ($urandom_range(0, 3) == 0);
				default:   rsp.ready <= (span % 4 != 0);
			endcase
		end
	end

	// watchdog on cycles with no request and no result moving
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("Test completed with failures");
		$finish;
	end

	// one request, then the sender's burst and gap pattern
	task automatic post_event(input logic [FUNC_W-1:0] f, input logic [PEER_W-1:0] a);
		int gap;
		req.valid     <= 1'b1;
		req.func      <= f;
		req.peer_addr <= a;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) :
				$urandom_range(0, 7);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				req.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// stop sending and wait until every owed result has come
	task automatic settle();
		req.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (IDLE_TAIL) @(posedge clk);
	endtask

	// write all three registers, block idle
	task automatic set_regs(input logic [CFG_W-1:0] period, input logic [CFG_W-1:0] tmo,
			input logic [CFG_W-1:0] bcast);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_HELLO_PERIOD;
		cfg_data  <= period;
		@(posedge clk);
		cfg_index <= CFG_TIMEOUT;
		cfg_data  <= tmo;
		@(posedge clk);
		cfg_index <= CFG_BCAST_ADDR;
		cfg_data  <= bcast;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// random mix of events, mostly on a small address pool
	task automatic random_events(input int count);
		logic [FUNC_W-1:0] f;
		logic [PEER_W-1:0] a;
		int                pick;
		int                k;
		for (k = 0; k < count; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 40)
				f = FUNC_TICK;
			else if (pick < 75)
				f = FUNC_RECV;
			else if (pick < 95)
				f = FUNC_FAIL;
			else
				f = FUNC_UNUSED;
			if ($urandom_range(0, 4) == 0)
				a = $urandom_range(0, 255);
			else
				a = peer_pool[$urandom_range(0, POOL_SIZE - 1)];
			post_event(f, a);
			// occasional full drain mid phase
			if ($urandom_range(0, 24) == 0)
				settle();
		end
	endtask

	initial begin
		int i;
		arst_n        = 1'b0;
		req.valid     <= 1'b0;
		req.func      <= FUNC_TICK;
		req.peer_addr <= '0;
		cfg_we        <= 1'b0;
		cfg_index     <= CFG_HELLO_PERIOD;
		cfg_data      <= '0;
		burst_left    = 0;
		for (i = 0; i < POOL_SIZE; i++)
			peer_pool[i] = $urandom_range(0, 255);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: lowest settings, hello on every tick
		set_regs(8'd0, 8'd0, 8'd0);
		post_event(FUNC_TICK, 8'hFF);
		post_event(FUNC_UNUSED, 8'h00);
		// failure on an empty table still reports lost
		post_event(FUNC_FAIL, 8'h00);
		post_event(FUNC_RECV, 8'h00);
		post_event(FUNC_TICK, 8'h00);
		post_event(FUNC_TICK, 8'hA5);
		// known neighbor only refreshes
		post_event(FUNC_RECV, 8'h00);
		post_event(FUNC_RECV, 8'hFF);
		// fill the table, then one more with no room
		for (i = 1; i < MAX_NEIGHBORS - 1; i++)
			post_event(FUNC_RECV, PEER_W'(i * 17));
		post_event(FUNC_RECV, 8'h5A);
		post_event(FUNC_TICK, 8'h00);
		// remove the last entry, then the first one
		post_event(FUNC_FAIL, 8'hEE);
		post_event(FUNC_FAIL, 8'h00);
		post_event(FUNC_RECV, 8'h5A);
		settle();

		// random phases, hello period never decreases
		set_regs(8'd1, 8'd2, 8'($urandom_range(0, 255)));
		random_events(PHASE_ITEMS);
		settle();
		set_regs(8'd3, 8'd0, 8'd255);
		random_events(PHASE_ITEMS);
		settle();
		set_regs(8'd6, 8'($urandom_range(1, 5)), 8'($urandom_range(0, 255)));
		random_events(PHASE_ITEMS);
		settle();

		// highest settings: a receive from each of the first MAX_NEIGHBORS pool addresses and a run of ticks
		set_regs(8'd255, 8'd255, 8'($urandom_range(0, 255)));
		for (i = 0; i < MAX_NEIGHBORS; i++)
			post_event(FUNC_RECV, peer_pool[i]);
		for (i = 0; i < TICK_RUN; i++)
			post_event(FUNC_TICK, 8'($urandom_range(0, 255)));
		settle();

		set_regs(8'd255, TIMEOUT_RST, 8'($urandom_range(0, 255)));
		random_events(PHASE_ITEMS);
		settle();

		if (fail_count == 0 && pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/nlt_pkg.sv
src/nlt_if.sv
src/nlt_ram.sv
src/nlt_entry_unit.sv
src/neighbor_liveness_table.sv
test/neighbor_table_checker.sv
test/neighbor_liveness_table_tb.sv
